// File: rtl/lsc_pkg.sv
package lsc_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_INDEX_BITS_DEF = 10;
    localparam int OUTPUT_BITS_DEF     = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    localparam int WAVE_W  = 1;
    localparam int DIR_W   = 2;
    localparam int FREQ_W  = 32;
    localparam int SLOPE_W = 40;
    localparam int RAMP_W  = 24;
    localparam int GAIN_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN      = 3'd5;

    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    localparam logic [RAMP_W-1:0] RAMP_RESET = 24'd48000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int SLOPE_LO_W = 20;
    localparam int LO_PROD_W  = SLOPE_LO_W + RAMP_W;
    localparam int PROD_W     = 64;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 24;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MAG_W      = 24;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        MUL_SLOPE_LO,
        MUL_SLOPE_HI,
        MUL_GAIN
    } mul_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     lo_en;
        logic     freq_en;
        logic     sweep_step;
        logic     lookup;
        logic     tone_step;
        logic     load_out;
    } lsc_cmd_t;

    typedef struct packed {
        logic waveform;
        logic out_blocked;
    } lsc_status_t;

    // quarter-wave entry j, Q30 Taylor series of sin up to the 17th power
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned j,
                                                    input int unsigned qbits,
                                                    input int unsigned obits);
        longint unsigned a;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned amp;
        longint unsigned v;
        a    = (HALF_PI_Q30 * 64'(j) + (64'd1 << (qbits - 1))) >> qbits;
        term = a;
        sum  = a;
        amp  = (64'd1 << (obits - 1)) - 64'd1;
        for (int n = 1; n <= 8; n++)
        begin
            term = (((term * a) >> 30) * a) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                default: term = term / 272;
            endcase
            if ((n & 1) != 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * amp + (64'd1 << 29)) >> 30;
        if (v > amp)
        begin
            v = amp;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

// File: rtl/lsc_ctrl.sv
module lsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 request_valid,
    input  logic                 sample_request,
    output logic                 request_stall,
    input  lsc_pkg::lsc_status_t status,
    output lsc_pkg::lsc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_FREQ,
        S_ADVANCE,
        S_LOOKUP,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   stall_reg;

    assign request_stall = stall_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = lsc_pkg::MUL_GAIN;
        case (state_reg)
            S_MUL_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lsc_pkg::MUL_SLOPE_LO;
            end
            S_MUL_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lsc_pkg::MUL_SLOPE_HI;
                cmd.lo_en   = 1'b1;
            end
            S_FREQ:
            begin
                cmd.freq_en = 1'b1;
            end
            S_ADVANCE:
            begin
                cmd.sweep_step = 1'b1;
            end
            S_LOOKUP:
            begin
                cmd.lookup    = 1'b1;
                cmd.tone_step = ~status.waveform;
            end
            S_SCALE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lsc_pkg::MUL_GAIN;
            end
            S_FINISH:
            begin
                cmd.load_out = ~status.out_blocked;
            end
            default:
            begin
                cmd.mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (request_valid && sample_request)
                    begin
                        state_reg <= status.waveform ? S_MUL_LO : S_LOOKUP;
                        stall_reg <= 1'b1;
                    end
                end
                S_MUL_LO:  state_reg <= S_MUL_HI;
                S_MUL_HI:  state_reg <= S_FREQ;
                S_FREQ:    state_reg <= S_ADVANCE;
                S_ADVANCE: state_reg <= S_LOOKUP;
                S_LOOKUP:  state_reg <= S_SCALE;
                S_SCALE:   state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (!status.out_blocked)
                    begin
                        state_reg <= S_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: rtl/lsc_datapath.sv
module lsc_datapath #(
    parameter int PHASE_BITS      = lsc_pkg::PHASE_BITS_DEF,
    parameter int SINE_INDEX_BITS = lsc_pkg::SINE_INDEX_BITS_DEF,
    parameter int OUTPUT_BITS     = lsc_pkg::OUTPUT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  lsc_pkg::lsc_cmd_t                   cmd,
    output lsc_pkg::lsc_status_t                status,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [OUTPUT_BITS-1:0]       sample,
    output logic                                ramp_rising,
    output logic                                turnaround
);

    localparam int QBITS  = SINE_INDEX_BITS - 2;
    localparam int QTR    = 1 << QBITS;
    localparam int ADDR_W = SINE_INDEX_BITS - 1;
    localparam int TAB_W  = OUTPUT_BITS - 1;
    localparam int R_W    = lsc_pkg::MUL_P_W - lsc_pkg::GAIN_FRAC;
    localparam logic [R_W-1:0] AMP_R = R_W'((64'd1 << (OUTPUT_BITS - 1)) - 64'd1);
    localparam logic [lsc_pkg::MUL_P_W-1:0] ROUND_HALF =
        lsc_pkg::MUL_P_W'(64'd1 << (lsc_pkg::GAIN_FRAC - 1));

    // configuration registers
    logic                          waveform_reg;
    logic [lsc_pkg::DIR_W-1:0]     dir_reg;
    logic [lsc_pkg::FREQ_W-1:0]    start_reg;
    logic [lsc_pkg::SLOPE_W-1:0]   slope_reg;
    logic [lsc_pkg::RAMP_W-1:0]    ramp_len_reg;
    logic [lsc_pkg::GAIN_W-1:0]    gain_reg;

    // generator state
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [lsc_pkg::RAMP_W-1:0]    pos_reg;
    logic                          up_reg;

    // working registers
    logic signed [lsc_pkg::MUL_P_W-1:0] mul_reg;
    logic [lsc_pkg::LO_PROD_W-1:0]      lo_reg;
    logic [PHASE_BITS-1:0]              freq_reg;
    logic [TAB_W-1:0]                   mag_reg;
    logic                               neg_reg;
    logic                               rising_reg;
    logic                               turn_reg;

    // output word
    logic                               out_valid_reg;
    logic signed [OUTPUT_BITS-1:0]      sample_reg;
    logic                               rising_out_reg;
    logic                               turn_out_reg;

    assign result_valid       = out_valid_reg;
    assign sample             = sample_reg;
    assign ramp_rising        = rising_out_reg;
    assign turnaround         = turn_out_reg;
    assign status.waveform    = waveform_reg;
    assign status.out_blocked = out_valid_reg & result_stall;

    // quarter-wave table
    logic [TAB_W-1:0] rom [QTR+1];

    for (genvar j = 0; j <= QTR; j++)
    begin : g_rom
        localparam logic [lsc_pkg::MAG_W-1:0] ENTRY =
            lsc_pkg::sine_entry(j, QBITS, OUTPUT_BITS);
        assign rom[j] = ENTRY[TAB_W-1:0];
    end

    logic [SINE_INDEX_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [ADDR_W-1:0]          addr;

    always_comb
    begin
        idx  = phase_reg[PHASE_BITS-1 -: SINE_INDEX_BITS];
        quad = idx[SINE_INDEX_BITS-1 -: 2];
        if (quad[0])
        begin
            addr = ADDR_W'(QTR) - {1'b0, idx[QBITS-1:0]};
        end
        else
        begin
            addr = {1'b0, idx[QBITS-1:0]};
        end
    end

    // shared multiplier
    logic signed [lsc_pkg::MUL_A_W-1:0] mul_a;
    logic [lsc_pkg::MUL_B_W-1:0]        mul_b;
    logic signed [lsc_pkg::MUL_P_W-1:0] mul_p;

    always_comb
    begin
        case (cmd.mul_sel)
            lsc_pkg::MUL_SLOPE_LO:
            begin
                mul_a = lsc_pkg::MUL_A_W'({1'b0, slope_reg[lsc_pkg::SLOPE_LO_W-1:0]});
                mul_b = lsc_pkg::MUL_B_W'(pos_reg);
            end
            lsc_pkg::MUL_SLOPE_HI:
            begin
                mul_a = lsc_pkg::MUL_A_W'(
                    $signed(slope_reg[lsc_pkg::SLOPE_W-1:lsc_pkg::SLOPE_LO_W]));
                mul_b = lsc_pkg::MUL_B_W'(pos_reg);
            end
            default:
            begin
                mul_a = lsc_pkg::MUL_A_W'({1'b0, mag_reg});
                mul_b = lsc_pkg::MUL_B_W'(gain_reg);
            end
        endcase
        mul_p = lsc_pkg::MUL_P_W'(mul_a) * lsc_pkg::MUL_P_W'($signed({1'b0, mul_b}));
    end

    // frequency word from the two partial products
    logic [63:0]                       start64;
    logic signed [lsc_pkg::PROD_W-1:0] hi_ext;
    logic signed [lsc_pkg::PROD_W-1:0] full_prod;
    logic [PHASE_BITS-1:0]             freq_next;

    always_comb
    begin
        start64   = 64'(start_reg);
        hi_ext    = lsc_pkg::PROD_W'(mul_reg);
        full_prod = (hi_ext <<< lsc_pkg::SLOPE_LO_W)
                    + $signed(lsc_pkg::PROD_W'(lo_reg));
        freq_next = start64[PHASE_BITS-1:0]
                    + full_prod[lsc_pkg::FRAC_BITS +: PHASE_BITS];
    end

    // ramp step
    logic [lsc_pkg::RAMP_W-1:0] pos_inc;
    logic [lsc_pkg::RAMP_W-1:0] pos_dec;
    logic [lsc_pkg::RAMP_W-1:0] pos_step;
    logic                       up_step;
    logic                       turn_step;

    always_comb
    begin
        pos_inc   = pos_reg + lsc_pkg::RAMP_W'(1);
        pos_dec   = (pos_reg != '0) ? pos_reg - lsc_pkg::RAMP_W'(1) : '0;
        pos_step  = pos_reg;
        up_step   = up_reg;
        turn_step = 1'b0;
        if (up_reg)
        begin
            pos_step = pos_inc;
            if (pos_inc >= ramp_len_reg)
            begin
                turn_step = 1'b1;
                if (dir_reg == lsc_pkg::DIR_FORWARD)
                begin
                    pos_step = '0;
                end
                else
                begin
                    up_step = 1'b0;
                end
            end
        end
        else
        begin
            pos_step = pos_dec;
            if (pos_dec == '0)
            begin
                turn_step = 1'b1;
                if (dir_reg == lsc_pkg::DIR_BACKWARD)
                begin
                    pos_step = ramp_len_reg;
                end
                else
                begin
                    up_step = 1'b1;
                end
            end
        end
    end

    // configuration write and re-arm values
    logic                       cfg_hit;
    logic [lsc_pkg::DIR_W-1:0]  dir_new;
    logic [lsc_pkg::RAMP_W-1:0] ramp_new;

    always_comb
    begin
        cfg_hit  = cfg_write && (cfg_index <= lsc_pkg::REG_GAIN);
        dir_new  = (cfg_index == lsc_pkg::REG_DIRECTION)
                   ? cfg_data[lsc_pkg::DIR_W-1:0] : dir_reg;
        ramp_new = (cfg_index == lsc_pkg::REG_RAMP)
                   ? cfg_data[lsc_pkg::RAMP_W-1:0] : ramp_len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= 1'b0;
            dir_reg      <= '0;
            start_reg    <= '0;
            slope_reg    <= '0;
            ramp_len_reg <= lsc_pkg::RAMP_RESET;
            gain_reg     <= lsc_pkg::GAIN_RESET;
            phase_reg    <= '0;
            pos_reg      <= '0;
            up_reg       <= 1'b1;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                lsc_pkg::REG_WAVEFORM:  waveform_reg <= cfg_data[0];
                lsc_pkg::REG_DIRECTION: dir_reg      <= cfg_data[lsc_pkg::DIR_W-1:0];
                lsc_pkg::REG_START:     start_reg    <= cfg_data[lsc_pkg::FREQ_W-1:0];
                lsc_pkg::REG_SLOPE:     slope_reg    <= cfg_data[lsc_pkg::SLOPE_W-1:0];
                lsc_pkg::REG_RAMP:      ramp_len_reg <= cfg_data[lsc_pkg::RAMP_W-1:0];
                default:                gain_reg     <= cfg_data[lsc_pkg::GAIN_W-1:0];
            endcase
            phase_reg <= '0;
            if (dir_new == lsc_pkg::DIR_BACKWARD)
            begin
                pos_reg <= ramp_new;
                up_reg  <= 1'b0;
            end
            else
            begin
                pos_reg <= '0;
                up_reg  <= 1'b1;
            end
        end
        else if (cmd.sweep_step)
        begin
            phase_reg <= phase_reg + freq_reg;
            pos_reg   <= pos_step;
            up_reg    <= up_step;
        end
        else if (cmd.tone_step)
        begin
            phase_reg <= phase_reg + start64[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            mul_reg <= mul_p;
        end
        if (cmd.lo_en)
        begin
            lo_reg <= mul_reg[lsc_pkg::LO_PROD_W-1:0];
        end
        if (cmd.freq_en)
        begin
            freq_reg <= freq_next;
        end
        if (cmd.sweep_step)
        begin
            rising_reg <= up_reg;
            turn_reg   <= turn_step;
        end
        else if (cmd.tone_step)
        begin
            rising_reg <= 1'b0;
            turn_reg   <= 1'b0;
        end
        if (cmd.lookup)
        begin
            mag_reg <= rom[addr];
            neg_reg <= quad[1];
        end
    end

    // round, saturate and apply sign
    logic [lsc_pkg::MUL_P_W-1:0] m_round;
    logic [R_W-1:0]              r_mag;
    logic [R_W-1:0]              r_sat;
    logic [OUTPUT_BITS-1:0]      sample_next;

    always_comb
    begin
        m_round = $unsigned(mul_reg) + ROUND_HALF;
        r_mag   = m_round[lsc_pkg::MUL_P_W-1:lsc_pkg::GAIN_FRAC];
        if (neg_reg)
        begin
            r_sat       = (r_mag > AMP_R + R_W'(1)) ? AMP_R + R_W'(1) : r_mag;
            sample_next = '0 - r_sat[OUTPUT_BITS-1:0];
        end
        else
        begin
            r_sat       = (r_mag > AMP_R) ? AMP_R : r_mag;
            sample_next = r_sat[OUTPUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_reg     <= $signed(sample_next);
            rising_out_reg <= rising_reg;
            turn_out_reg   <= turn_reg;
        end
    end

endmodule

// File: rtl/linear_sweep_chirp_generator.sv
// Tone and linear-chirp DDS source. Each accepted request word with
// sample_request set yields one sample word; a request word with it clear is
// dropped. No new request is taken until the current sample is finished.
// The single 25x24 multiplier does the work: a sweep uses it twice for the
// 40-bit slope times ramp position product and once for the gain, a tone
// only for the gain, with one registered read of the quarter-wave table in
// between. The finished word sits in an output register and waits there
// under stall while the next request is taken; a request that reaches the
// output stage while the previous word is still held waits for it. Any
// write to a register in the list re-arms phase and ramp; the user must write
// only while no sample is in flight, as the block itself does not enforce it.
module linear_sweep_chirp_generator #(
    parameter int PHASE_BITS      = lsc_pkg::PHASE_BITS_DEF,
    parameter int SINE_INDEX_BITS = lsc_pkg::SINE_INDEX_BITS_DEF,
    parameter int OUTPUT_BITS     = lsc_pkg::OUTPUT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             request_valid,
    output logic                             request_stall,
    input  logic                             sample_request,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [OUTPUT_BITS-1:0]    sample,
    output logic                             ramp_rising,
    output logic                             turnaround,
    input  logic                             cfg_write,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lsc_pkg::lsc_cmd_t    cmd;
    lsc_pkg::lsc_status_t status;

    lsc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .sample_request (sample_request),
        .request_stall  (request_stall),
        .status         (status),
        .cmd            (cmd)
    );

    lsc_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_INDEX_BITS (SINE_INDEX_BITS),
        .OUTPUT_BITS     (OUTPUT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample       (sample),
        .ramp_rising  (ramp_rising),
        .turnaround   (turnaround)
    );

endmodule

// File: rtl/lsc_checker.sv
module lsc_checker #(
    parameter int OUTPUT_BITS = lsc_pkg::OUTPUT_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             request_valid,
    input logic                             request_stall,
    input logic                             sample_request,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic signed [OUTPUT_BITS-1:0]    sample,
    input logic                             ramp_rising,
    input logic                             turnaround,
    input logic                             cfg_write
);

    // hold a stalled result word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(sample) && $stable(ramp_rising) && $stable(turnaround))
        else $error("stalled result word changed");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall && sample_request |=> request_stall)
        else $error("no busy phase after a sample request");

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall && !sample_request |=> !request_stall)
        else $error("empty request word was not dropped");

    a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !request_stall && $past(request_stall))
        else $error("result word appeared outside the end of a sample");

    a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !request_stall)
        else $error("register write while a sample is in flight");

endmodule

bind linear_sweep_chirp_generator lsc_checker #(
    .OUTPUT_BITS (OUTPUT_BITS)
) u_lsc_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int OUT_W = lsc_pkg::OUTPUT_BITS_DEF;
    localparam int QTR = 1 << (lsc_pkg::SINE_INDEX_BITS_DEF - 2);
    localparam longint unsigned AMP = (64'd1 << (OUT_W - 1)) - 64'd1;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [lsc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [lsc_pkg::DIR_W-1:0] DIR_UP_DOWN = 2'd0;
    localparam logic [lsc_pkg::DIR_W-1:0] DIR_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [OUT_W-1:0] sample;
        logic                    rising;
        logic                    turn;
    } sample_word_t;

    logic                               clk;
    logic                               rst_n;
    logic                               request_valid;
    logic                               request_stall;
    logic                               sample_request;
    logic                               result_valid;
    logic                               result_stall;
    logic signed [OUT_W-1:0]            sample;
    logic                               ramp_rising;
    logic                               turnaround;
    logic                               cfg_write;
    logic [lsc_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [lsc_pkg::CFG_DATA_W-1:0]     cfg_data;

    // shadow configuration and state of the generator
    logic                               wave_sel;
    logic [lsc_pkg::DIR_W-1:0]          sweep_dir;
    logic [lsc_pkg::FREQ_W-1:0]         start_word;
    logic signed [lsc_pkg::SLOPE_W-1:0] slope;
    logic [lsc_pkg::RAMP_W-1:0]         ramp_len;
    logic [lsc_pkg::GAIN_W-1:0]         gain_q14;
    logic [31:0]                        phase;
    logic [lsc_pkg::RAMP_W-1:0]         ramp_pos;
    logic                               ramp_up;

    longint unsigned quarter_wave [0:QTR];
    sample_word_t    expected_words [$];
    sample_word_t    want_word;
    int              mismatch_count;
    int              cycle_count;
    int              hold_cycles;
    logic            idle_on;

    linear_sweep_chirp_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .sample_request(sample_request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample        (sample),
        .ramp_rising   (ramp_rising),
        .turnaround    (turnaround),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void build_quarter_wave();
        longint unsigned a;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        for (int j = 0; j <= QTR; j++)
        begin
            a = (QUARTER_TURN_Q30 * 64'(j) + 64'(QTR / 2)) / 64'(QTR);
            term = a;
            sum = a;
            for (int n = 1; n <= 8; n++)
            begin
                term = (((term * a) >> 30) * a) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum * AMP + (64'd1 << 29)) >> 30;
            if (v > AMP)
            begin
                v = AMP;
            end
            quarter_wave[j] = v;
        end
    endfunction

    function automatic logic [OUT_W-1:0] shape_sample(input logic [31:0] ph);
        logic [9:0]      idx;
        int              off;
        longint unsigned mag;
        longint unsigned r;
        idx = ph[31:22];
        off = int'(idx[7:0]);
        mag = idx[8] ? quarter_wave[QTR - off] : quarter_wave[off];
        r = (mag * 64'(gain_q14) + 64'd8192) >> lsc_pkg::GAIN_FRAC;
        if (idx[9])
        begin
            if (r > AMP + 64'd1)
            begin
                r = AMP + 64'd1;
            end
            r = -r;
        end
        else if (r > AMP)
        begin
            r = AMP;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic void rearm_generator();
        phase = '0;
        if (sweep_dir == lsc_pkg::DIR_BACKWARD)
        begin
            ramp_pos = ramp_len;
            ramp_up = 1'b0;
        end
        else
        begin
            ramp_pos = '0;
            ramp_up = 1'b1;
        end
    endfunction

    function automatic sample_word_t next_sample_word();
        sample_word_t  w;
        longint signed prod;
        longint signed shifted;
        logic [31:0]   freq;
        w.turn = 1'b0;
        if (!wave_sel)
        begin
            w.sample = shape_sample(phase);
            w.rising = 1'b0;
            phase = phase + start_word;
            return w;
        end
        prod = longint'(slope) * longint'({40'd0, ramp_pos});
        shifted = prod >>> lsc_pkg::FRAC_BITS;
        freq = start_word + shifted[31:0];
        phase = phase + freq;
        w.rising = ramp_up;
        if (ramp_up)
        begin
            ramp_pos = ramp_pos + lsc_pkg::RAMP_W'(1);
            if (ramp_pos >= ramp_len)
            begin
                w.turn = 1'b1;
                if (sweep_dir == lsc_pkg::DIR_FORWARD)
                begin
                    ramp_pos = '0;
                end
                else
                begin
                    ramp_up = 1'b0;
                end
            end
        end
        else
        begin
            if (ramp_pos != '0)
            begin
                ramp_pos = ramp_pos - lsc_pkg::RAMP_W'(1);
            end
            if (ramp_pos == '0)
            begin
                w.turn = 1'b1;
                if (sweep_dir == lsc_pkg::DIR_BACKWARD)
                begin
                    ramp_pos = ramp_len;
                end
                else
                begin
                    ramp_up = 1'b1;
                end
            end
        end
        w.sample = shape_sample(phase);
        return w;
    endfunction

    task automatic send_word(input logic req);
        while (idle_on && $urandom_range(99) < 12)
        begin
            request_valid <= 1'b0;
            @(negedge clk);
        end
        request_valid <= 1'b1;
        sample_request <= req;
        @(posedge clk);
        while (request_stall)
        begin
            @(posedge clk);
        end
        if (req)
        begin
            expected_words.push_back(next_sample_word());
        end
        @(negedge clk);
    endtask

    task automatic send_burst(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_word($urandom_range(19) != 0);
        end
    endtask

    task automatic wait_for_samples();
        request_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(input logic [lsc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lsc_pkg::CFG_DATA_W-1:0] data);
        logic known;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        known = 1'b1;
        case (idx)
            lsc_pkg::REG_WAVEFORM:  wave_sel = data[0];
            lsc_pkg::REG_DIRECTION: sweep_dir = data[lsc_pkg::DIR_W-1:0];
            lsc_pkg::REG_START:     start_word = data[lsc_pkg::FREQ_W-1:0];
            lsc_pkg::REG_SLOPE:     slope = data[lsc_pkg::SLOPE_W-1:0];
            lsc_pkg::REG_RAMP:      ramp_len = data[lsc_pkg::RAMP_W-1:0];
            lsc_pkg::REG_GAIN:      gain_q14 = data[lsc_pkg::GAIN_W-1:0];
            default:                known = 1'b0;
        endcase
        if (known)
        begin
            rearm_generator();
        end
    endtask

    task automatic load_sweep(input logic [lsc_pkg::DIR_W-1:0] dir,
                              input logic [lsc_pkg::FREQ_W-1:0] start,
                              input logic [lsc_pkg::SLOPE_W-1:0] rate,
                              input logic [lsc_pkg::RAMP_W-1:0] len);
        set_reg(lsc_pkg::REG_WAVEFORM, 40'd1);
        set_reg(lsc_pkg::REG_START, 40'(start));
        set_reg(lsc_pkg::REG_SLOPE, rate);
        set_reg(lsc_pkg::REG_RAMP, 40'(len));
        set_reg(lsc_pkg::REG_DIRECTION, 40'(dir));
    endtask

    task automatic load_random_setting();
        logic [lsc_pkg::CFG_DATA_W-1:0]  value [6];
        logic [lsc_pkg::CFG_INDEX_W-1:0] order [6];
        logic [lsc_pkg::CFG_INDEX_W-1:0] tmp;
        logic [63:0]                     rnd;
        int                              widths [6];
        int                              pick;
        int                              r;
        widths = '{lsc_pkg::WAVE_W, lsc_pkg::DIR_W, lsc_pkg::FREQ_W,
                   lsc_pkg::SLOPE_W, lsc_pkg::RAMP_W, lsc_pkg::GAIN_W};
        value[lsc_pkg::REG_WAVEFORM] = 40'($urandom_range(3) != 0);
        value[lsc_pkg::REG_DIRECTION] = 40'($urandom_range(3));
        value[lsc_pkg::REG_START] = 40'($urandom);
        case ($urandom_range(5))
            0:       value[lsc_pkg::REG_SLOPE] = 40'h7F_FFFF_FFFF;
            1:       value[lsc_pkg::REG_SLOPE] = 40'h80_0000_0000;
            2:       value[lsc_pkg::REG_SLOPE] =
                         40'(signed'($urandom_range(65535)) - 32768) << 16;
            default: value[lsc_pkg::REG_SLOPE] = {8'($urandom), 32'($urandom)};
        endcase
        case ($urandom_range(9))
            0:       value[lsc_pkg::REG_RAMP] = 40'd0;
            1:       value[lsc_pkg::REG_RAMP] = 40'hFF_FFFF;
            2:       value[lsc_pkg::REG_RAMP] = 40'($urandom_range(1000));
            default: value[lsc_pkg::REG_RAMP] = 40'($urandom_range(24, 1));
        endcase
        case ($urandom_range(4))
            0:       value[lsc_pkg::REG_GAIN] = 40'd0;
            1:       value[lsc_pkg::REG_GAIN] = 40'hFFFF;
            2:       value[lsc_pkg::REG_GAIN] = 40'(lsc_pkg::GAIN_RESET);
            default: value[lsc_pkg::REG_GAIN] = 40'($urandom_range(65535));
        endcase
        for (int k = 0; k < 6; k++)
        begin
            order[k] = lsc_pkg::CFG_INDEX_W'(k);
            if (widths[k] < lsc_pkg::CFG_DATA_W && $urandom_range(3) == 0)
            begin
                rnd = {$urandom, $urandom};
                value[k] = value[k]
                           | ((rnd[lsc_pkg::CFG_DATA_W-1:0] >> widths[k]) << widths[k]);
            end
        end
        for (int k = 5; k > 0; k--)
        begin
            pick = int'($urandom_range(k));
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
        end
        for (int k = 0; k < 6; k++)
        begin
            r = int'(order[k]);
            set_reg(order[k], value[r]);
        end
    endtask

    task automatic test_reset_defaults();
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        wait_for_samples();
    endtask

    task automatic test_tone_extremes();
        set_reg(lsc_pkg::REG_GAIN, 40'hFFFF);
        set_reg(lsc_pkg::REG_START, 40'h00_4000_0000);
        repeat (4) send_word(1'b1);
        wait_for_samples();
        set_reg(lsc_pkg::REG_START, 40'h00_FFFF_FFFF);
        set_reg(REG_UNUSED, 40'hFF_FFFF_FFFF);
        repeat (2) send_word(1'b1);
        wait_for_samples();
        set_reg(lsc_pkg::REG_START, 40'h00_8000_0000);
        set_reg(lsc_pkg::REG_GAIN, 40'd0);
        send_word(1'b1);
        wait_for_samples();
        set_reg(lsc_pkg::REG_GAIN, 40'(lsc_pkg::GAIN_RESET));
    endtask

    task automatic test_sweep_directions();
        load_sweep(lsc_pkg::DIR_FORWARD, 32'h1000_0000, 40'h7F_FFFF_FFFF, 24'd3);
        repeat (4) send_word(1'b1);
        wait_for_samples();
        load_sweep(lsc_pkg::DIR_BACKWARD, 32'h0800_0000, 40'h80_0000_0000, 24'd3);
        repeat (4) send_word(1'b1);
        wait_for_samples();
        load_sweep(DIR_UP_DOWN, 32'h0100_0000, 40'h00_0100_0000, 24'd2);
        repeat (5) send_word(1'b1);
        wait_for_samples();
        load_sweep(DIR_SPARE, 32'h0200_0000, 40'hFF_FF00_0000, 24'd1);
        repeat (3) send_word(1'b1);
        wait_for_samples();
    endtask

    task automatic test_zero_ramp();
        load_sweep(DIR_UP_DOWN, 32'h0300_0000, 40'h00_0010_0000, 24'd0);
        repeat (3) send_word(1'b1);
        wait_for_samples();
        load_sweep(lsc_pkg::DIR_BACKWARD, 32'h0300_0000, 40'h00_0010_0000, 24'd0);
        repeat (2) send_word(1'b1);
        wait_for_samples();
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            load_random_setting();
            send_burst($urandom_range(per_phase + 20, per_phase - 20));
            wait_for_samples();
        end
    endtask

    task automatic test_backpressure();
        load_random_setting();
        set_reg(lsc_pkg::REG_WAVEFORM, 40'd1);
        hold_cycles <= 300;
        send_burst(40);
        wait_for_samples();
    endtask

    task automatic test_drained_pause();
        load_random_setting();
        send_burst(30);
        wait_for_samples();
        send_burst(30);
        wait_for_samples();
    endtask

    task automatic test_steady_stream();
        load_random_setting();
        set_reg(lsc_pkg::REG_WAVEFORM, 40'd1);
        idle_on = 1'b0;
        send_burst(200);
        wait_for_samples();
        idle_on = 1'b1;
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            result_stall <= idle_on && ($urandom_range(99) < 12);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("sample word with none pending: sample %0d", sample);
                mismatch_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (sample !== want_word.sample)
                begin
                    $error("sample: expected %0d, actual %0d", want_word.sample, sample);
                    mismatch_count++;
                end
                if (ramp_rising !== want_word.rising)
                begin
                    $error("ramp_rising: expected %0b, actual %0b", want_word.rising,
                           ramp_rising);
                    mismatch_count++;
                end
                if (turnaround !== want_word.turn)
                begin
                    $error("turnaround: expected %0b, actual %0b", want_word.turn, turnaround);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        request_valid = 1'b0;
        sample_request = 1'b0;
        result_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        build_quarter_wave();
        wave_sel = 1'b0;
        sweep_dir = DIR_UP_DOWN;
        start_word = '0;
        slope = '0;
        ramp_len = lsc_pkg::RAMP_RESET;
        gain_q14 = lsc_pkg::GAIN_RESET;
        rearm_generator();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_tone_extremes();
        test_sweep_directions();
        test_zero_ramp();
        test_random_settings(16, 50);
        test_backpressure();
        test_drained_pause();
        test_steady_stream();

        if (mismatch_count == 0 && expected_words.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
